// ----- design/rfp_pkg.sv -----
// rfp_pkg: shared types, character codes, frame kinds and result codes
// for the frame parser; no dependencies
package rfp_pkg;

  localparam int NEST_DEPTH_DEF = 8;
  localparam int CFG_W          = 4;
  localparam int LEVEL_W        = 4;
  localparam int VALUE_W        = 64;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_F     = 8'h66;

  localparam logic [3:0] CFG_RESET = 4'd8;

  typedef enum logic [2:0] {
    EV_PAYLOAD = 3'd0,
    EV_SCALAR  = 3'd1,
    EV_STRING  = 3'd2,
    EV_ARRAY   = 3'd3,
    EV_ERROR   = 3'd4
  } event_e;

  typedef enum logic [3:0] {
    K_INT     = 4'd0,
    K_SIMPLE  = 4'd1,
    K_ERROR   = 4'd2,
    K_BIGNUM  = 4'd3,
    K_NULL    = 4'd4,
    K_BOOL    = 4'd5,
    K_BULK    = 4'd6,
    K_BULKERR = 4'd7,
    K_ARRAY   = 4'd8,
    K_UNDEF   = 4'd9
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_EMPTY    = 3'd1,
    ERR_INVALID  = 3'd2,
    ERR_NUMBER   = 3'd3,
    ERR_TOO_DEEP = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_LINE,
    PH_DATA,
    PH_CR,
    PH_LF
  } phase_e;

  typedef struct packed {
    logic neg;
    logic digit;
    logic stop;
    logic ovf;
  } num_flags_t;

  typedef struct packed {
    logic finish;
    logic push;
    logic clear;
  } stk_ctrl_t;

  function automatic kind_e kind_of(input logic [7:0] b);
    kind_e k;
    case (b)
      8'h3A:   k = K_INT;
      8'h2B:   k = K_SIMPLE;
      8'h2D:   k = K_ERROR;
      8'h28:   k = K_BIGNUM;
      8'h5F:   k = K_NULL;
      8'h23:   k = K_BOOL;
      8'h24:   k = K_BULK;
      8'h21:   k = K_BULKERR;
      8'h2A:   k = K_ARRAY;
      default: k = K_UNDEF;
    endcase
    return k;
  endfunction

endpackage

// ----- design/rfp_digit.sv -----
// rfp_digit: one decimal digit step of the length / integer accumulator
// depends on rfp_pkg
module rfp_digit (
  input  logic [7:0]         byte_i,
  input  logic               first_i,
  input  logic [63:0]        accum_i,
  input  rfp_pkg::num_flags_t flags_i,
  output logic [63:0]        accum_o,
  output rfp_pkg::num_flags_t flags_o
);
  import rfp_pkg::*;

  logic [67:0] acc_ext;
  logic [67:0] prod;
  logic [67:0] lim;
  logic        is_digit;

  assign acc_ext  = {4'b0, accum_i};
  assign prod     = (acc_ext << 3) + (acc_ext << 1) + {64'b0, byte_i[3:0]};
  assign lim      = flags_i.neg ? {4'b0, 1'b1, 63'b0} : {4'b0, 1'b0, {63{1'b1}}};
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);

  always_comb begin
    accum_o = accum_i;
    flags_o = flags_i;
    if (!flags_i.stop) begin
      if (first_i && byte_i == CH_MINUS) begin
        flags_o.neg = 1'b1;
      end else if (is_digit) begin
        flags_o.digit = 1'b1;
        if (!flags_i.ovf) begin
          if (prod > lim) begin
            flags_o.ovf = 1'b1;
          end else begin
            accum_o = prod[63:0];
          end
        end
      end else begin
        flags_o.stop = 1'b1;
      end
    end
  end

endmodule

// ----- design/rfp_stack.sv -----
// rfp_stack: stack of remaining element counts for open arrays
// depends on rfp_pkg
module rfp_stack #(
  parameter int NEST_DEPTH = rfp_pkg::NEST_DEPTH_DEF,
  localparam int NW = $clog2(NEST_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rfp_pkg::stk_ctrl_t ctrl_i,
  input  logic [63:0]        push_count_i,
  output logic [NW-1:0]      nest_o,
  output logic [NW-1:0]      closed_o
);
  import rfp_pkg::*;

  localparam int IW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  logic [63:0]           cnt_q [NEST_DEPTH];
  logic [NEST_DEPTH-1:0] one_q;
  logic [NW-1:0]         nest_q;
  logic [NW-1:0]         closed;
  logic [NW-1:0]         top_lvl;
  logic                  has_top;
  logic [IW-1:0]         top_idx;
  logic [IW-1:0]         push_idx;
  logic [63:0]           top_cnt;

  // count of innermost arrays sitting on their last element
  always_comb begin
    logic          run;
    logic [NW-1:0] idx;
    run    = 1'b1;
    closed = '0;
    for (int k = 0; k < NEST_DEPTH; k++) begin
      idx = nest_q - NW'(k) - NW'(1);
      if (run && (NW'(k) < nest_q)) begin
        if (one_q[IW'(idx)]) begin
          closed = closed + NW'(1);
        end else begin
          run = 1'b0;
        end
      end
    end
  end

  assign top_lvl  = nest_q - closed;
  assign has_top  = (top_lvl != '0);
  assign top_idx  = IW'(top_lvl - NW'(1));
  assign push_idx = IW'(nest_q);
  assign top_cnt  = cnt_q[top_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nest_q <= '0;
      one_q  <= '0;
    end else if (ctrl_i.clear) begin
      nest_q <= '0;
    end else if (ctrl_i.push) begin
      nest_q          <= nest_q + NW'(1);
      one_q[push_idx] <= (push_count_i == 64'd1);
    end else if (ctrl_i.finish) begin
      nest_q <= top_lvl;
      if (has_top) begin
        one_q[top_idx] <= (top_cnt == 64'd2);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      cnt_q[push_idx] <= push_count_i;
    end else if (ctrl_i.finish && has_top) begin
      cnt_q[top_idx] <= top_cnt - 64'd1;
    end
  end

  assign nest_o   = nest_q;
  assign closed_o = closed;

endmodule

// ----- design/resp_frame_parser.sv -----
// resp_frame_parser: top level of the byte-wide frame parser
// depends on rfp_pkg, rfp_digit and rfp_stack
//
// usage
// - input channel: one stream byte per item on stream_byte_i, taken at a
//   rising edge with in_valid_i high and in_stall_o low
// - output channel: at most one result item per input item, held in an
//   output register and taken when out_valid_o is high and out_stall_i low
// - result: written to the output register at the edge that takes its byte
// - throughput: one byte per cycle while in_stall_o is low; the limit is the
//   per-byte update of the parser state, the digit step and the array count stack
// - a new byte is taken while a result waits, unless the receiver is
//   stalling that result, in which case in_stall_o rises for that cycle
// - cfg_we_i / cfg_data_i write the nesting limit (0 acts as 1, values above
//   NEST_DEPTH act as NEST_DEPTH); write only while the parser is idle
// - reset: parser waits for a top level type byte, no arrays open, limit 8,
//   output register empty; the count stack holds no data until pushed
// - an error result drops every open array and returns to top level
module resp_frame_parser #(
  parameter int NEST_DEPTH = rfp_pkg::NEST_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rfp_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  stream_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  event_res_o,
  output logic [3:0]                  kind_o,
  output logic signed [63:0]          value_o,
  output logic [7:0]                  payload_o,
  output logic [2:0]                  error_code_o,
  output logic [rfp_pkg::LEVEL_W-1:0] level_o,
  output logic [3:0]                  closed_arrays_o
);
  import rfp_pkg::*;

  localparam int NW = $clog2(NEST_DEPTH + 1);
  localparam int CW = (NW > CFG_W) ? NW + 1 : CFG_W + 1;

  // parser state
  phase_e       phase_q, phase_d;
  kind_e        kind_q, kind_d;
  logic [63:0]  accum_q, accum_d;
  num_flags_t   flags_q, flags_d;
  logic [63:0]  rem_q, rem_d;
  logic [1:0]   len_q, len_d;
  logic [7:0]   held_q, held_d;
  logic         cr_q, cr_d;
  logic         sticky_q, sticky_d;
  logic [CFG_W-1:0] max_nest_q;

  // output register
  logic         out_valid_q;
  event_e       ev_q;
  kind_e        rkind_q;
  logic [63:0]  val_q;
  logic [7:0]   pay_q;
  err_e         err_q;
  logic [LEVEL_W-1:0] lvl_q;
  logic [3:0]   closed_q;

  // result of this byte
  logic         r_valid;
  event_e       r_ev;
  kind_e        r_kind;
  logic [63:0]  r_val;
  logic [7:0]   r_pay;
  err_e         r_err;

  logic         acc;
  logic [7:0]   b;
  kind_e        kb;
  stk_ctrl_t    stk_ctrl, stk_ctrl_g;
  logic [NW-1:0] nest, closed;
  logic [63:0]  dig_accum;
  num_flags_t   dig_flags;
  logic [63:0]  numv;
  logic         num_ok;
  logic [CW-1:0] lim, nest_ext, maxd_ext;
  logic         type_deep, push_deep;
  logic [1:0]   len_inc;

  // line end decode
  err_e         le_err;
  event_e       le_ev;
  logic [63:0]  le_val;
  logic         le_fin, le_push, le_data;

  assign b          = stream_byte_i;
  assign kb         = kind_of(b);
  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;

  assign num_ok  = flags_q.digit && !flags_q.ovf;
  assign numv    = flags_q.neg ? (64'd0 - accum_q) : accum_q;
  assign len_inc = (len_q == 2'd3) ? len_q : len_q + 2'd1;

  // effective nesting limit, clamped to 1..NEST_DEPTH
  assign maxd_ext = CW'(NEST_DEPTH);
  assign nest_ext = CW'(nest);
  always_comb begin
    lim = CW'(max_nest_q);
    if (lim == '0) lim = CW'(1);
    if (lim > maxd_ext) lim = maxd_ext;
  end
  assign type_deep = (nest_ext >= lim);
  assign push_deep = (nest_ext + CW'(1) >= lim) || (nest_ext >= maxd_ext);

  rfp_digit u_digit (
    .byte_i  (b),
    .first_i (len_q == 2'd0),
    .accum_i (accum_q),
    .flags_i (flags_q),
    .accum_o (dig_accum),
    .flags_o (dig_flags)
  );

  rfp_stack #(.NEST_DEPTH(NEST_DEPTH)) u_stack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (stk_ctrl_g),
    .push_count_i (numv),
    .nest_o       (nest),
    .closed_o     (closed)
  );

  assign stk_ctrl_g = acc ? stk_ctrl : '0;

  // what a line feed ends: completion, bulk body, array header or error
  always_comb begin
    le_err  = ERR_NONE;
    le_ev   = EV_SCALAR;
    le_val  = '0;
    le_fin  = 1'b0;
    le_push = 1'b0;
    le_data = 1'b0;
    if (len_q == 2'd0) begin
      le_err = ERR_EMPTY;
    end else if (!cr_q || sticky_q) begin
      le_err = ERR_INVALID;
    end else begin
      case (kind_q)
        K_INT: begin
          if (!num_ok) le_err = ERR_NUMBER;
          else begin
            le_val = numv;
            le_fin = 1'b1;
          end
        end
        K_SIMPLE, K_ERROR, K_BIGNUM: begin
          le_ev  = EV_STRING;
          le_fin = 1'b1;
        end
        K_NULL: begin
          if (len_q != 2'd1) le_err = ERR_INVALID;
          else le_fin = 1'b1;
        end
        K_BOOL: begin
          if (len_q == 2'd2 && held_q == CH_T) begin
            le_val = 64'd1;
            le_fin = 1'b1;
          end else if (len_q == 2'd2 && held_q == CH_F) begin
            le_fin = 1'b1;
          end else begin
            le_err = ERR_INVALID;
          end
        end
        K_BULK, K_BULKERR: begin
          if (!num_ok) le_err = ERR_NUMBER;
          else if (numv == {64{1'b1}}) begin
            // null bulk
            le_ev  = EV_STRING;
            le_val = numv;
            le_fin = 1'b1;
          end else if (numv == '0 || numv[63]) begin
            le_err = ERR_INVALID;
          end else begin
            le_data = 1'b1;
          end
        end
        default: begin
          le_ev = EV_ARRAY;
          if (!num_ok) le_err = ERR_NUMBER;
          else if (numv == '0 || numv[63]) begin
            // empty array completes at once
            le_fin = 1'b1;
          end else if (push_deep) begin
            le_err = ERR_TOO_DEEP;
          end else begin
            le_val  = numv;
            le_push = 1'b1;
          end
        end
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_TYPE: phase_d = (type_deep || kb == K_UNDEF) ? PH_TYPE : PH_LINE;
      PH_LINE: begin
        if (b == CH_LF) begin
          phase_d = (le_err == ERR_NONE && le_data) ? PH_DATA : PH_TYPE;
        end
      end
      PH_DATA: phase_d = (rem_q == 64'd1) ? PH_CR : PH_DATA;
      PH_CR:   phase_d = PH_LF;
      PH_LF:   phase_d = PH_TYPE;
      default: phase_d = PH_TYPE;
    endcase
  end

  // datapath and result of this byte
  always_comb begin
    kind_d   = kind_q;
    accum_d  = accum_q;
    flags_d  = flags_q;
    rem_d    = rem_q;
    len_d    = len_q;
    held_d   = held_q;
    cr_d     = cr_q;
    sticky_d = sticky_q;
    r_valid  = 1'b0;
    r_ev     = EV_PAYLOAD;
    r_kind   = kind_q;
    r_val    = '0;
    r_pay    = '0;
    r_err    = ERR_NONE;
    stk_ctrl = '0;
    case (phase_q)
      PH_TYPE: begin
        kind_d   = kb;
        accum_d  = '0;
        flags_d  = '0;
        len_d    = '0;
        held_d   = '0;
        cr_d     = 1'b0;
        sticky_d = 1'b0;
        rem_d    = '0;
        r_kind   = kb;
        if (type_deep) begin
          r_valid        = 1'b1;
          r_ev           = EV_ERROR;
          r_err          = ERR_TOO_DEEP;
          stk_ctrl.clear = 1'b1;
        end else if (kb == K_UNDEF) begin
          r_valid         = 1'b1;
          r_ev            = EV_SCALAR;
          stk_ctrl.finish = 1'b1;
        end
      end
      PH_LINE: begin
        if (b == CH_LF) begin
          if (le_err != ERR_NONE) begin
            r_valid        = 1'b1;
            r_ev           = EV_ERROR;
            r_err          = le_err;
            stk_ctrl.clear = 1'b1;
          end else if (le_data) begin
            rem_d = numv;
          end else begin
            r_valid         = 1'b1;
            r_ev            = le_ev;
            r_val           = le_val;
            stk_ctrl.finish = le_fin;
            stk_ctrl.push   = le_push;
          end
        end else if (b == CH_CR) begin
          if (cr_q) sticky_d = 1'b1;
          cr_d  = 1'b1;
          len_d = len_inc;
        end else begin
          if (cr_q) sticky_d = 1'b1;
          cr_d    = 1'b0;
          accum_d = dig_accum;
          flags_d = dig_flags;
          if (len_q == 2'd0) held_d = b;
          len_d = len_inc;
          // line strings stream their content
          if (kind_q == K_SIMPLE || kind_q == K_ERROR || kind_q == K_BIGNUM) begin
            r_valid = 1'b1;
            r_pay   = b;
          end
        end
      end
      PH_DATA: begin
        rem_d   = rem_q - 64'd1;
        r_valid = 1'b1;
        r_pay   = b;
      end
      PH_CR: begin
        if (b != CH_CR) sticky_d = 1'b1;
      end
      PH_LF: begin
        if (b != CH_LF || sticky_q) begin
          r_valid        = 1'b1;
          r_ev           = EV_ERROR;
          r_err          = ERR_INVALID;
          stk_ctrl.clear = 1'b1;
        end else begin
          r_valid         = 1'b1;
          r_ev            = EV_STRING;
          stk_ctrl.finish = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TYPE;
      kind_q     <= K_INT;
      accum_q    <= '0;
      flags_q    <= '0;
      rem_q      <= '0;
      len_q      <= '0;
      held_q     <= '0;
      cr_q       <= 1'b0;
      sticky_q   <= 1'b0;
      max_nest_q <= CFG_RESET;
    end else begin
      if (cfg_we_i) max_nest_q <= cfg_data_i;
      if (acc) begin
        phase_q  <= phase_d;
        kind_q   <= kind_d;
        accum_q  <= accum_d;
        flags_q  <= flags_d;
        rem_q    <= rem_d;
        len_q    <= len_d;
        held_q   <= held_d;
        cr_q     <= cr_d;
        sticky_q <= sticky_d;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= r_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ev_q     <= r_ev;
      rkind_q  <= r_kind;
      val_q    <= r_val;
      pay_q    <= r_pay;
      err_q    <= r_err;
      lvl_q    <= LEVEL_W'(nest);
      closed_q <= stk_ctrl.finish ? 4'(closed) : 4'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = ev_q;
  assign kind_o          = rkind_q;
  assign value_o         = val_q;
  assign payload_o       = pay_q;
  assign error_code_o    = err_q;
  assign level_o         = lvl_q;
  assign closed_arrays_o = closed_q;

  // an error leaves no array open
  a_err_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && r_valid && r_ev == EV_ERROR |=> nest == '0 && phase_q == PH_TYPE)
    else $error("open arrays survive an error");

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(ev_q) && $stable(val_q))
    else $error("stalled result overwritten");

  // stack never exceeds its storage
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nest_ext <= maxd_ext)
    else $error("nesting beyond stack depth");

  // a push happens only below the limit
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_ctrl_g.push |-> nest_ext + CW'(1) < lim)
    else $error("array opened at the nesting limit");

endmodule
